FILE: src/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// shared widths, constants, codes and datapath control types for the
// rans symbol encoder
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int FREQ_W  = 13;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;
    localparam int BYTE_W  = 8;

    localparam int NUM_SYMBOLS_DEF = 256;
    localparam int TOTAL_FREQ      = 4096;

    localparam logic [DATA_W-1:0] LOWER_BOUND = 32'd65536;

    // renormalization bound is BOUND_K * freq
    localparam longint BOUND_K = 64'd2147483648 / TOTAL_FREQ;
    localparam int     K_W     = $clog2(BOUND_K + 1);
    localparam int     BOUND_W = (K_W + FREQ_W > DATA_W + 1) ? K_W + FREQ_W : DATA_W + 1;

    // cumulative sum plus remainder
    localparam int ACC_W = SYM_W + FREQ_W + 1;

    localparam int MAX_EMIT  = 2;
    localparam int EMIT_W    = 2;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [COUNT_W-1:0] BITS_BYTE = 6'd8;
    localparam logic [COUNT_W-1:0] BITS_WORD = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LAT_FREQ,
        OP_ACC_ADD,
        OP_BOUND,
        OP_CMP,
        OP_SHIFT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIN1,
        OP_FIN2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sym_ok;
    } t_dp_ctrl;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic              ge;
    } t_dp_stat;

endpackage

FILE: src/rse_freq_mem.sv
// ----------------------------------------------------------------------------
// rse_freq_mem
// frequency table: one write port, one registered read port, per-entry
// valid bits so that unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module rse_freq_mem import rse_pkg::*; #(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
    localparam int IDX_W = $clog2(NUM_SYMBOLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [FREQ_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [FREQ_W-1:0] o_rdata
);

    logic [FREQ_W-1:0]      r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_valid;
    logic [FREQ_W-1:0]      r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        r_rvld  <= r_valid[i_raddr];
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

FILE: src/rse_datapath.sv
// ----------------------------------------------------------------------------
// rse_datapath
// coder state and work registers around one shared 32-bit add/subtract
// unit, used for the cumulative sum, bound compare, division and update
// ----------------------------------------------------------------------------
module rse_datapath import rse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctrl          i_ctrl,
    input  logic [FREQ_W-1:0] i_rdata,
    output t_dp_stat          o_stat
);

    localparam logic [BOUND_W-1:0] K_V  = BOUND_W'(BOUND_K);
    localparam logic [DATA_W-1:0]  TF_V = DATA_W'(TOTAL_FREQ);

    logic [DATA_W-1:0]  r_x;
    logic [ACC_W-1:0]   r_acc;
    logic [FREQ_W-1:0]  r_freq;
    logic [BOUND_W-1:0] r_bound;
    logic               r_ge;
    logic [DATA_W-1:0]  r_quo;
    logic [FREQ_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_prod;

    logic [DATA_W-1:0]  alu_a;
    logic [DATA_W-1:0]  alu_b;
    logic               alu_sub;
    logic [DATA_W:0]    alu_res;
    logic [FREQ_W:0]    div_t;
    logic [FREQ_W-1:0]  f_eff;

    assign div_t = {r_rem, r_quo[DATA_W-1]};
    assign f_eff = (i_ctrl.sym_ok && i_rdata != '0) ? i_rdata : FREQ_W'(1);

    // shared add/subtract unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (i_ctrl.op)
            OP_ACC_ADD: begin
                alu_a = DATA_W'(r_acc);
                alu_b = DATA_W'(i_rdata);
            end
            OP_CMP: begin
                alu_a   = r_x;
                alu_b   = r_bound[DATA_W-1:0];
                alu_sub = 1'b1;
            end
            OP_DIV_STEP: begin
                alu_a   = DATA_W'(div_t);
                alu_b   = DATA_W'(r_freq);
                alu_sub = 1'b1;
            end
            OP_FIN1: begin
                alu_a = DATA_W'(r_acc);
                alu_b = DATA_W'(r_rem);
            end
            OP_FIN2: begin
                alu_a = r_prod;
                alu_b = DATA_W'(r_acc);
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (DATA_W+1)'(alu_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= LOWER_BOUND;
        end else begin
            unique case (i_ctrl.op)
                OP_NONE: begin
                end
                OP_CLEAR: begin
                    r_acc <= '0;
                end
                OP_LAT_FREQ: begin
                    r_freq <= f_eff;
                end
                OP_ACC_ADD: begin
                    r_acc <= alu_res[ACC_W-1:0];
                end
                OP_BOUND: begin
                    r_bound <= K_V * BOUND_W'(r_freq);
                end
                OP_CMP: begin
                    r_ge <= alu_res[DATA_W] && (r_bound[BOUND_W-1:DATA_W] == '0);
                end
                OP_SHIFT: begin
                    r_x <= r_x >> BYTE_W;
                end
                OP_DIV_INIT: begin
                    r_quo <= r_x;
                    r_rem <= '0;
                end
                OP_DIV_STEP: begin
                    r_quo <= {r_quo[DATA_W-2:0], alu_res[DATA_W]};
                    r_rem <= alu_res[DATA_W] ? alu_res[FREQ_W-1:0] : div_t[FREQ_W-1:0];
                end
                OP_FIN1: begin
                    r_acc  <= alu_res[ACC_W-1:0];
                    r_prod <= r_quo * TF_V;
                end
                OP_FIN2: begin
                    r_x <= alu_res[DATA_W-1:0];
                end
            endcase
        end
    end

    assign o_stat.x  = r_x;
    assign o_stat.ge = r_ge;

endmodule

FILE: src/rans_symbol_encoder_unit.sv
// ----------------------------------------------------------------------------
// rans_symbol_encoder_unit
// rANS encoder with 32-bit state and byte renormalization; sequencer that
// drives the frequency table and the shared arithmetic datapath
//
// channel   direction  transfer
// command   in         start && !busy: i_command, i_symbol, i_freq_value
// result    out        o_strobe: o_out_bits, o_bit_count, o_last
//
// load and flush are taken without leaving idle; flush result follows on the next cycle
// encode holds busy while the table read port walks the table entries, one entry
// per cycle, and then through the 32 division steps
// busy is high for the whole encode; up to two byte results come out
// synchronous active-low reset clears the table valid bits and the state
// results cannot be stalled
// ----------------------------------------------------------------------------
module rans_symbol_encoder_unit import rse_pkg::*; #(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic [FREQ_W-1:0]  i_freq_value,
    output logic               o_strobe,
    output logic [DATA_W-1:0]  o_out_bits,
    output logic [COUNT_W-1:0] o_bit_count,
    output logic               o_last
);

    localparam int IDX_W = $clog2(NUM_SYMBOLS);
    localparam int LIM_W = IDX_W + 1;

    localparam logic [LIM_W-1:0]  NUM_LIM  = LIM_W'(NUM_SYMBOLS);
    localparam logic [SYM_W:0]    NUM_SYM  = (SYM_W+1)'(NUM_SYMBOLS);
    localparam logic [DATA_W-1:0] TF_V     = DATA_W'(TOTAL_FREQ);
    localparam logic [FREQ_W-1:0] FREQ_SAT = FREQ_W'(TOTAL_FREQ);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDF,
        S_LATF,
        S_SUM,
        S_BOUND,
        S_CMP,
        S_EMIT,
        S_DIV,
        S_FIN1,
        S_FIN2
    } t_state;

    t_state               r_state;
    logic [SYM_W-1:0]     r_sym;
    logic [LIM_W-1:0]     r_idx;
    logic [LIM_W-1:0]     r_lim;
    logic                 r_pend;
    logic [EMIT_W-1:0]    r_n;
    logic                 r_have;
    logic [BYTE_W-1:0]    r_pbyte;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_strobe;
    logic [DATA_W-1:0]    r_out_bits;
    logic [COUNT_W-1:0]   r_bit_count;
    logic                 r_last;

    logic              accept;
    logic              in_ok;
    logic              sym_ok;
    logic              emit_more;
    logic              mem_we;
    logic [FREQ_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [FREQ_W-1:0] mem_rdata;
    t_dp_ctrl          dp_ctrl;
    t_dp_stat          dp_stat;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign in_ok     = {1'b0, i_symbol} < NUM_SYM;
    assign sym_ok    = {1'b0, r_sym} < NUM_SYM;
    assign emit_more = dp_stat.ge && (r_n < EMIT_W'(MAX_EMIT));

    assign mem_we    = accept && (i_command == CMD_LOAD) && in_ok;
    assign mem_wdata = (DATA_W'(i_freq_value) > TF_V) ? FREQ_SAT : i_freq_value;
    assign mem_raddr = (r_state == S_RDF) ? (sym_ok ? r_sym[IDX_W-1:0] : '0)
                                          : r_idx[IDX_W-1:0];

    rse_freq_mem #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_freq_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (i_symbol[IDX_W-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rse_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dp_ctrl),
        .i_rdata (mem_rdata),
        .o_stat  (dp_stat)
    );

    always_comb begin
        dp_ctrl.sym_ok = sym_ok;
        dp_ctrl.op     = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_command == CMD_ENCODE) begin
                    dp_ctrl.op = OP_CLEAR;
                end
            end
            S_RDF: begin
                dp_ctrl.op = OP_NONE;
            end
            S_LATF: begin
                dp_ctrl.op = OP_LAT_FREQ;
            end
            S_SUM: begin
                if (r_pend) begin
                    dp_ctrl.op = OP_ACC_ADD;
                end
            end
            S_BOUND: begin
                dp_ctrl.op = OP_BOUND;
            end
            S_CMP: begin
                dp_ctrl.op = OP_CMP;
            end
            S_EMIT: begin
                dp_ctrl.op = emit_more ? OP_SHIFT : OP_DIV_INIT;
            end
            S_DIV: begin
                dp_ctrl.op = OP_DIV_STEP;
            end
            S_FIN1: begin
                dp_ctrl.op = OP_FIN1;
            end
            S_FIN2: begin
                dp_ctrl.op = OP_FIN2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            r_have   <= 1'b0;
            r_n      <= '0;
            r_idx    <= '0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sym  <= i_symbol;
                        r_lim  <= in_ok ? LIM_W'(i_symbol) : NUM_LIM;
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (i_command == CMD_ENCODE) begin
                            r_state <= S_RDF;
                        end else if (i_command == CMD_FLUSH) begin
                            r_strobe    <= 1'b1;
                            r_out_bits  <= dp_stat.x;
                            r_bit_count <= BITS_WORD;
                            r_last      <= 1'b1;
                        end
                    end
                end
                S_RDF: begin
                    r_state <= S_LATF;
                end
                S_LATF: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_idx < r_lim) begin
                        r_idx  <= r_idx + LIM_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    r_n     <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_more) begin
                        if (r_have) begin
                            r_strobe    <= 1'b1;
                            r_out_bits  <= DATA_W'(r_pbyte);
                            r_bit_count <= BITS_BYTE;
                            r_last      <= 1'b0;
                        end
                        r_pbyte <= dp_stat.x[BYTE_W-1:0];
                        r_have  <= 1'b1;
                        r_n     <= r_n + EMIT_W'(1);
                        r_state <= S_CMP;
                    end else begin
                        if (r_have) begin
                            r_strobe    <= 1'b1;
                            r_out_bits  <= DATA_W'(r_pbyte);
                            r_bit_count <= BITS_BYTE;
                            r_last      <= 1'b1;
                        end
                        r_have  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                        r_state <= S_FIN1;
                    end
                end
                S_FIN1: begin
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_bits  = r_out_bits;
    assign o_bit_count = r_bit_count;
    assign o_last      = r_last;

endmodule

FILE: bench/rans_symbol_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// rans_symbol_encoder_unit_tb
// self-checking bench for the rans symbol encoder: a directed run through
// table loads, saturation, zero entries, the top symbol, the unused command
// and two-byte renormalization, then random traffic of all four commands under
// three idling profiles; a scoreboard predicts every emitted byte and flush
// word and compares them in order with the strobed results
// ----------------------------------------------------------------------------
module rans_symbol_encoder_unit_tb;
    import rse_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 400;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_emit;

    class coder_scoreboard;
        logic [DATA_W-1:0] coder_x;
        logic [FREQ_W-1:0] freq_tab [NUM_SYMBOLS_DEF];
        t_emit             emitted_q [$];
        int                errors;

        function new();
            coder_x = LOWER_BOUND;
            foreach (freq_tab[i]) freq_tab[i] = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_command(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                   input logic [FREQ_W-1:0] fv);
            logic [FREQ_W-1:0] f;
            logic [DATA_W-1:0] cum;
            logic [DATA_W-1:0] x;
            logic [DATA_W-1:0] nxt;
            logic [63:0]       bound;
            t_emit             e;
            int                n;
            case (cmd)
                CMD_LOAD: begin
                    if (int'(sym) < NUM_SYMBOLS_DEF)
                        freq_tab[sym] = (fv > TOTAL_FREQ) ? FREQ_W'(TOTAL_FREQ) : fv;
                end
                CMD_ENCODE: begin
                    f = (freq_tab[sym] == '0) ? FREQ_W'(1) : freq_tab[sym];
                    cum = '0;
                    for (int i = 0; i < int'(sym); i++) cum += DATA_W'(freq_tab[i]);
                    bound = 64'(BOUND_K) * 64'(f);
                    x = coder_x;
                    n = 0;
                    while (n < MAX_EMIT && 64'(x) >= bound) begin
                        nxt = x >> 8;
                        e.value = DATA_W'(x[BYTE_W-1:0]);
                        e.count = BITS_BYTE;
                        e.last  = (n + 1 == MAX_EMIT) || (64'(nxt) < bound);
                        emitted_q.push_back(e);
                        x = nxt;
                        n++;
                    end
                    coder_x = (x / DATA_W'(f)) * DATA_W'(TOTAL_FREQ) + cum + (x % DATA_W'(f));
                end
                CMD_FLUSH: begin
                    e.value = coder_x;
                    e.count = BITS_WORD;
                    e.last  = 1'b1;
                    emitted_q.push_back(e);
                end
                default: ;
            endcase
        endfunction

        task check_result(input logic [DATA_W-1:0] value, input logic [COUNT_W-1:0] count,
                          input logic last);
            t_emit e;
            if (emitted_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result bits=%h count=%0d last=%b",
                                          value, count, last));
            end else begin
                e = emitted_q.pop_front();
                if (value !== e.value)
                    report_mismatch($sformatf("out_bits %h, expected %h", value, e.value));
                if (count !== e.count)
                    report_mismatch($sformatf("bit_count %0d, expected %0d", count, e.count));
                if (last !== e.last)
                    report_mismatch($sformatf("last %b, expected %b", last, e.last));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_command;
    logic [SYM_W-1:0]   i_symbol;
    logic [FREQ_W-1:0]  i_freq_value;
    logic               o_strobe;
    logic [DATA_W-1:0]  o_out_bits;
    logic [COUNT_W-1:0] o_bit_count;
    logic               o_last;
    int                 cycles = 0;

    coder_scoreboard sb = new();

    rans_symbol_encoder_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_symbol     (i_symbol),
        .i_freq_value (i_freq_value),
        .o_strobe     (o_strobe),
        .o_out_bits   (o_out_bits),
        .o_bit_count  (o_bit_count),
        .o_last       (o_last)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_out_bits, o_bit_count, o_last);
    end

    // called just after a falling edge; returns just after the falling edge that follows acceptance
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [FREQ_W-1:0] fv);
        i_command    = cmd;
        i_symbol     = sym;
        i_freq_value = fv;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, sym, fv);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n_items, input int idle_pct);
        int                done;
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [FREQ_W-1:0] fv;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 22)      cmd = CMD_LOAD;
            else if (pick < 82) cmd = CMD_ENCODE;
            else if (pick < 95) cmd = CMD_FLUSH;
            else                cmd = CMD_UNUSED;
            sym = ($urandom_range(9) < 7) ? SYM_W'($urandom_range(31)) : SYM_W'($urandom);
            pick = $urandom_range(9);
            if (pick < 3)      fv = FREQ_W'($urandom_range(15));
            else if (pick < 8) fv = FREQ_W'($urandom_range(TOTAL_FREQ));
            else               fv = FREQ_W'($urandom);
            while ($urandom_range(99) < idle_pct) begin
                start = 1'b0;
                @(negedge i_clk);
            end
            send_item(cmd, sym, fv);
            if (cmd != CMD_UNUSED) done++;
        end
    endtask

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = CMD_LOAD;
        i_symbol     = '0;
        i_freq_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, then two-byte renormalization
        send_item(CMD_FLUSH,  8'd0,   13'd0);
        send_item(CMD_ENCODE, 8'd0,   13'd0);
        send_item(CMD_ENCODE, 8'd0,   13'd0);
        send_item(CMD_FLUSH,  8'd0,   13'd0);
        // saturation, full scale, top index, zero entry
        send_item(CMD_LOAD,   8'd0,   13'h1FFF);
        send_item(CMD_LOAD,   8'd1,   13'd4096);
        send_item(CMD_LOAD,   8'd255, 13'd1);
        send_item(CMD_LOAD,   8'd128, 13'd0);
        send_item(CMD_UNUSED, 8'd255, 13'h1FFF);
        send_item(CMD_ENCODE, 8'd255, 13'd0);
        send_item(CMD_ENCODE, 8'd128, 13'd0);
        send_item(CMD_ENCODE, 8'd0,   13'd0);
        send_item(CMD_ENCODE, 8'd1,   13'h1FFF);
        send_item(CMD_FLUSH,  8'd255, 13'h1FFF);
        send_item(CMD_LOAD,   8'd170, 13'h1555);
        send_item(CMD_LOAD,   8'd85,  13'h0AAA);
        send_item(CMD_ENCODE, 8'd170, 13'd0);
        send_item(CMD_ENCODE, 8'd85,  13'd0);
        send_item(CMD_ENCODE, 8'd85,  13'd0);
        send_item(CMD_FLUSH,  8'd0,   13'd0);

        run_random(210, 33);
        run_random(210, 88);
        run_random(210, 0);
        start = 1'b0;

        waited = 0;
        while (sb.emitted_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (sb.emitted_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.emitted_q.size()));

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
